>>> rtl/core/wscd_pkg.sv
// Shared types and constants for the worker startup cost estimator.
`timescale 1ns / 1ps

package wscd_pkg;

    localparam int TOTAL_W    = 64;
    localparam int COUNT_W    = 32;
    localparam int STEP_CNT_W = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_PEAK,
        ST_EMIT
    } wscd_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/core/wscd_div.sv
// Bit-serial restoring divider: 64-bit total by 32-bit count, one quotient bit per cycle.
`timescale 1ns / 1ps

module wscd_div
    import wscd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TOTAL_W-1:0] dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic [TOTAL_W-1:0] quotient,
    output div_stat_t          stat
);

    logic [TOTAL_W-1:0]    dvd_reg;
    logic [TOTAL_W-1:0]    dvd_next;
    logic [COUNT_W-1:0]    rem_reg;
    logic [COUNT_W-1:0]    rem_next;
    logic [COUNT_W-1:0]    dsr_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [COUNT_W:0]      trial;
    logic [COUNT_W:0]      diff;
    logic                  ge;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[TOTAL_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        dvd_next = {dvd_reg[TOTAL_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_CNT_W'(1);
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> rtl/core/worker_startup_cost_estimator.sv
// Top level: sample statistics, first-result peak tracking and the sequencer around the divider.
//
//  channel | dir | fields (low bit first)               | accepted when
//  s_*     | in  | tdata: mode, elapsed_ns              | s_tvalid & s_tready
//  m_*     | out | tdata: mean_ns, peak_excess_ns       | m_tvalid & m_tready
//
// Each item passes from accept to result through one divider load, 64 divider
// steps (one quotient bit per cycle), one mean latch, one peak update, one emit.
// The block then returns to idle; it takes no new item until the last is emitted.
// The serial divider sets the item rate; s_tready is high only in the idle state.
// A result waits in the output register until taken; the block stalls in the emit
// state while the previous result is still held. Reset clears the total, count and peak.
`timescale 1ns / 1ps

module worker_startup_cost_estimator
    import wscd_pkg::*;
#(
    parameter int TIME_WIDTH = 48
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((1 + TIME_WIDTH + 7) / 8) * 8-1:0] s_tdata,   // mode, elapsed_ns
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((2 * TIME_WIDTH + 7) / 8) * 8-1:0] m_tdata    // mean_ns, peak_excess_ns
);

    wscd_state_t           state_reg;
    wscd_state_t           state_next;
    logic [TOTAL_W-1:0]    total_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [TIME_WIDTH-1:0] peak_reg;
    logic [TIME_WIDTH-1:0] mean_reg;
    logic                  mode_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [TIME_WIDTH-1:0] mean_out_reg;
    logic [TIME_WIDTH-1:0] peak_out_reg;
    logic                  m_tvalid_reg;

    logic                  accept;
    logic                  div_start;
    logic                  emit;
    logic [TOTAL_W-1:0]    quotient;
    div_stat_t             div_stat;
    logic [TOTAL_W:0]      sum;
    logic [TIME_WIDTH:0]   excess;
    logic [TIME_WIDTH-1:0] mean_sat;
    logic                  in_mode;
    logic [TIME_WIDTH-1:0] in_time;

    assign in_mode = s_tdata[0];
    assign in_time = s_tdata[TIME_WIDTH:1];

    wscd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (count_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_START;
            end
            ST_START:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_PEAK;
            end
            ST_PEAK:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_START: div_start = 1'b1;
            ST_EMIT:  emit      = !m_tvalid_reg || m_tready;
            default:
            begin
                s_tready  = 1'b0;
                div_start = 1'b0;
                emit      = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        sum    = {1'b0, total_reg} + {{(TOTAL_W - TIME_WIDTH + 1){1'b0}}, in_time};
        excess = {1'b0, time_reg} - {1'b0, mean_reg};
        if (count_reg == '0)
            mean_sat = '0;
        else if (|quotient[TOTAL_W-1:TIME_WIDTH])
            mean_sat = '1;
        else
            mean_sat = quotient[TIME_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            count_reg    <= '0;
            peak_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && !in_mode)
            begin
                total_reg <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                if (count_reg != '1)
                    count_reg <= count_reg + COUNT_W'(1);
            end
            if (state_reg == ST_PEAK && mode_reg && !excess[TIME_WIDTH]
                && excess[TIME_WIDTH-1:0] > peak_reg)
                peak_reg <= excess[TIME_WIDTH-1:0];
            if (emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= in_mode;
            time_reg <= in_time;
        end
        if (div_stat.done)
            mean_reg <= mean_sat;
        if (emit)
        begin
            mean_out_reg <= mean_reg;
            peak_out_reg <= peak_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        m_tdata                             = '0;
        m_tdata[TIME_WIDTH-1:0]             = mean_out_reg;
        m_tdata[2*TIME_WIDTH-1:TIME_WIDTH]  = peak_out_reg;
    end

endmodule

>>> bench/worker_startup_cost_estimator_tb.sv
// Testbench for the worker startup cost estimator: directed table, random events, scoreboard.
`timescale 1ns / 1ps

module worker_startup_cost_estimator_tb;

    localparam int TIME_W = 48;
    localparam int IN_W   = 56;
    localparam int OUT_W  = 96;

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [63:0]       TOTAL_MAX = {64{1'b1}};
    localparam logic [31:0]       COUNT_MAX = {32{1'b1}};
    localparam int                RANDOM_PER_PHASE = 400;

    typedef enum logic {
        EV_SAMPLE       = 1'b0,
        EV_FIRST_RESULT = 1'b1
    } ev_kind_t;

    typedef struct packed {
        logic [TIME_W-1:0] mean;
        logic [TIME_W-1:0] peak;
    } stats_t;

    typedef struct {
        ev_kind_t          kind;
        logic [TIME_W-1:0] t;
        logic              known;
        stats_t            want;
    } row_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata  = '0;   // mode, elapsed_ns
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;         // mean_ns, peak_excess_ns

    logic [63:0]        acc_total = '0;
    logic [31:0]        acc_count = '0;
    logic [TIME_W-1:0]  acc_peak  = '0;

    stats_t             pending_stats[$];
    row_t               plan[$];

    int                 errors        = 0;
    int                 checked       = 0;
    int                 sample_events = 0;
    int                 first_events  = 0;
    int                 peak_raises   = 0;
    int                 src_idle_pct  = 16;
    int                 dst_stall_pct = 56;

    worker_startup_cost_estimator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [TIME_W-1:0] mean_of();
        logic [63:0] q;
        if (acc_count == '0)
            return '0;
        q = acc_total / {32'd0, acc_count};
        return (q > {16'd0, TIME_MAX}) ? TIME_MAX : q[TIME_W-1:0];
    endfunction

    function automatic stats_t advance_stats(ev_kind_t kind, logic [TIME_W-1:0] t);
        stats_t            r;
        logic [TIME_W-1:0] avg;
        logic [TIME_W-1:0] excess;
        if (kind == EV_SAMPLE)
        begin
            if (acc_total > TOTAL_MAX - {16'd0, t})
                acc_total = TOTAL_MAX;
            else
                acc_total = acc_total + {16'd0, t};
            if (acc_count != COUNT_MAX)
                acc_count = acc_count + 32'd1;
        end
        else
        begin
            avg = mean_of();
            if (t > avg)
            begin
                excess = t - avg;
                if (excess > acc_peak)
                begin
                    acc_peak = excess;
                    peak_raises++;
                end
            end
        end
        r.mean = mean_of();
        r.peak = acc_peak;
        return r;
    endfunction

    function automatic row_t mk_row(ev_kind_t k, logic [TIME_W-1:0] t, logic known,
                                    logic [TIME_W-1:0] mean, logic [TIME_W-1:0] peak);
        row_t r;
        r.kind      = k;
        r.t         = t;
        r.known     = known;
        r.want.mean = mean;
        r.want.peak = peak;
        return r;
    endfunction

    function automatic void add_row(row_t r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic void expect_stats(stats_t s);
        pending_stats.insert(pending_stats.size(), s);
    endfunction

    // optional gap, then present one item and hold it until taken
    task automatic send_event(input ev_kind_t kind, input logic [TIME_W-1:0] t);
        int gap;
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            gap = $urandom_range(1, 90);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W-TIME_W-1){1'b0}}, t, logic'(kind)};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == EV_SAMPLE)
            sample_events++;
        else
            first_events++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= dst_stall_pct);
    end

    always @(posedge clk)
    begin
        stats_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_stats.size() == 0)
            begin
                $display("%0t unexpected item: actual mean %0h peak %0h",
                         $time, m_tdata[TIME_W-1:0], m_tdata[2*TIME_W-1:TIME_W]);
                errors++;
            end
            else
            begin
                want = pending_stats.pop_front();
                checked++;
                if (m_tdata[TIME_W-1:0] !== want.mean)
                begin
                    $display("%0t mean_ns mismatch: expected %0h actual %0h",
                             $time, want.mean, m_tdata[TIME_W-1:0]);
                    errors++;
                end
                if (m_tdata[2*TIME_W-1:TIME_W] !== want.peak)
                begin
                    $display("%0t peak_excess_ns mismatch: expected %0h actual %0h",
                             $time, want.peak, m_tdata[2*TIME_W-1:TIME_W]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        stats_t            got;
        ev_kind_t          kind;
        logic [TIME_W-1:0] raw;
        logic [TIME_W-1:0] t;
        int                pick;

        // no samples yet, equal excess, delay below mean, then the extremes
        add_row(mk_row(EV_FIRST_RESULT, 48'd0,    1'b1, 48'd0,   48'd0));
        add_row(mk_row(EV_FIRST_RESULT, 48'd100,  1'b1, 48'd0,   48'd100));
        add_row(mk_row(EV_FIRST_RESULT, 48'd100,  1'b1, 48'd0,   48'd100));
        add_row(mk_row(EV_FIRST_RESULT, 48'd40,   1'b1, 48'd0,   48'd100));
        add_row(mk_row(EV_SAMPLE,       48'd0,    1'b1, 48'd0,   48'd100));
        add_row(mk_row(EV_SAMPLE,       48'd1000, 1'b1, 48'd500, 48'd100));
        add_row(mk_row(EV_FIRST_RESULT, 48'd550,  1'b1, 48'd500, 48'd100));
        add_row(mk_row(EV_FIRST_RESULT, 48'd300,  1'b1, 48'd500, 48'd100));
        add_row(mk_row(EV_FIRST_RESULT, 48'd700,  1'b1, 48'd500, 48'd200));
        add_row(mk_row(EV_FIRST_RESULT, 48'd700,  1'b1, 48'd500, 48'd200));
        add_row(mk_row(EV_SAMPLE,       TIME_MAX, 1'b0, '0, '0));
        add_row(mk_row(EV_SAMPLE,       TIME_MAX, 1'b0, '0, '0));
        add_row(mk_row(EV_FIRST_RESULT, TIME_MAX, 1'b0, '0, '0));
        add_row(mk_row(EV_SAMPLE,       48'h5555_5555_5555, 1'b0, '0, '0));
        add_row(mk_row(EV_FIRST_RESULT, 48'hAAAA_AAAA_AAAA, 1'b0, '0, '0));
        add_row(mk_row(EV_SAMPLE,       48'd1,    1'b0, '0, '0));
        add_row(mk_row(EV_FIRST_RESULT, 48'd0,    1'b0, '0, '0));
        add_row(mk_row(EV_SAMPLE,       TIME_MAX, 1'b0, '0, '0));
        add_row(mk_row(EV_FIRST_RESULT, TIME_MAX, 1'b0, '0, '0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send_event(plan[i].kind, plan[i].t);
            got = advance_stats(plan[i].kind, plan[i].t);
            expect_stats(plan[i].known ? plan[i].want : got);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin src_idle_pct = 16; dst_stall_pct <= 56; end
                1:       begin src_idle_pct = 56; dst_stall_pct <= 16; end
                default: begin src_idle_pct = 0;  dst_stall_pct <= 0;  end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                kind = ($urandom_range(0, 99) < 55) ? EV_SAMPLE : EV_FIRST_RESULT;
                pick = $urandom_range(0, 99);
                raw  = TIME_W'({$urandom, $urandom});
                if (pick < 4)
                    t = '0;
                else if (pick < 8)
                    t = TIME_MAX;
                else
                    t = raw >> $urandom_range(0, TIME_W-1);
                send_event(kind, t);
                expect_stats(advance_stats(kind, t));
            end
        end
        s_tvalid <= 1'b0;

        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("ran %0d sample and %0d first-result events, %0d results checked",
                 sample_events, first_events, checked);
        $display("peak excess rose %0d times, final peak %0h over %0d samples",
                 peak_raises, acc_peak, acc_count);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
